@@ design/rdq_pkg.sv @@
// Shared types and constants for the reversible deque.
package rdq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int ACTION_BITS   = 3;
  localparam int VALUE_BITS    = 32;
  localparam int COUNT_BITS    = 5;
  localparam int STATUS_BITS   = 2;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_REVERSE    = 3'd4
  } action_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } status_t;

  // what every cell of a chain does at a clock edge
  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_SHIFT_UP,
    MODE_SHIFT_DOWN,
    MODE_LOAD
  } mode_t;

  typedef struct packed {
    logic [ACTION_BITS-1:0]       action;
    logic signed [VALUE_BITS-1:0] value;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] front_value;
    logic signed [VALUE_BITS-1:0] back_value;
    logic [COUNT_BITS-1:0]        count;
    logic [STATUS_BITS-1:0]       status;
  } result_t;

endpackage

@@ design/reversible_deque.sv @@
// Top level: bounded deque of signed words with a constant-time reverse.
//
//   channel | direction | handshake                  | payload
//   item    | in        | item_valid / item_stall     | rdq_pkg::item_t
//   result  | out       | result_valid / result_stall | rdq_pkg::result_t
//
// One item per cycle while item_stall is low; each item's result appears in the cycle after acceptance.
// Two cell chains hold the same words in opposite order, so both ends sit at
// a cell 0 and no read mux over the store is needed; a push at the far end of
// a chain loads the cell whose index equals the count.
// Reset clears count, the reverse flag, result_valid and status; cell contents stay undefined.
// A stalled result holds the state, so item_stall follows result_stall.
module reversible_deque #(
  parameter int DEPTH     = rdq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = rdq_pkg::WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  rdq_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output rdq_pkg::result_t result
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic                     reversed;
  logic                     reversed_next;
  rdq_pkg::status_t         status;
  rdq_pkg::status_t         status_next;
  logic                     result_valid_next;

  logic                        accept;
  logic                        empty;
  logic                        full;
  logic                        at_head;
  logic signed [WORD_BITS-1:0] value_w;
  rdq_pkg::mode_t              head_mode;
  rdq_pkg::mode_t              tail_mode;
  logic signed [WORD_BITS-1:0] head_word;
  logic signed [WORD_BITS-1:0] tail_word;
  logic signed [rdq_pkg::VALUE_BITS-1:0] head_out;
  logic signed [rdq_pkg::VALUE_BITS-1:0] tail_out;

  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;
  assign empty      = (count == '0);
  assign full       = (count == CW'(DEPTH));
  assign value_w    = WORD_BITS'(item.value);

  always_comb begin
    count_next    = count;
    reversed_next = reversed;
    status_next   = rdq_pkg::ST_OK;
    head_mode     = rdq_pkg::MODE_HOLD;
    tail_mode     = rdq_pkg::MODE_HOLD;
    at_head       = 1'b0;
    if (accept) begin
      case (item.action)
        rdq_pkg::ACT_PUSH_BACK, rdq_pkg::ACT_PUSH_FRONT: begin
          at_head = (item.action == rdq_pkg::ACT_PUSH_FRONT) ^ reversed;
          if (full) begin
            status_next = rdq_pkg::ST_PUSH_FULL;
          end else begin
            count_next = count + CW'(1);
            head_mode  = at_head ? rdq_pkg::MODE_SHIFT_UP : rdq_pkg::MODE_LOAD;
            tail_mode  = at_head ? rdq_pkg::MODE_LOAD : rdq_pkg::MODE_SHIFT_UP;
          end
        end
        rdq_pkg::ACT_POP_BACK, rdq_pkg::ACT_POP_FRONT: begin
          at_head = (item.action == rdq_pkg::ACT_POP_FRONT) ^ reversed;
          if (empty) begin
            status_next = rdq_pkg::ST_POP_EMPTY;
          end else begin
            count_next = count - CW'(1);
            head_mode  = at_head ? rdq_pkg::MODE_SHIFT_DOWN : rdq_pkg::MODE_HOLD;
            tail_mode  = at_head ? rdq_pkg::MODE_HOLD : rdq_pkg::MODE_SHIFT_DOWN;
          end
        end
        rdq_pkg::ACT_REVERSE: reversed_next = ~reversed;
        default: ;
      endcase
    end
    result_valid_next = accept | item_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      reversed     <= 1'b0;
      result_valid <= 1'b0;
      status       <= rdq_pkg::ST_OK;
    end else begin
      count        <= count_next;
      reversed     <= reversed_next;
      result_valid <= result_valid_next;
      if (accept) status <= status_next;
    end
  end

  // head chain: cell 0 is the physical first word
  rdq_chain #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS),
    .CW       (CW)
  ) u_head (
    .clk     (clk),
    .mode    (head_mode),
    .count   (count),
    .value   (value_w),
    .end_word(head_word)
  );

  // tail chain: cell 0 is the physical last word
  rdq_chain #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS),
    .CW       (CW)
  ) u_tail (
    .clk     (clk),
    .mode    (tail_mode),
    .count   (count),
    .value   (value_w),
    .end_word(tail_word)
  );

  // state only moves on a transaction, so the payload holds while stalled
  assign head_out = rdq_pkg::VALUE_BITS'(head_word);
  assign tail_out = rdq_pkg::VALUE_BITS'(tail_word);

  always_comb begin
    if (empty) begin
      result.front_value = '1;
      result.back_value  = '1;
    end else begin
      result.front_value = reversed ? tail_out : head_out;
      result.back_value  = reversed ? head_out : tail_out;
    end
    result.count  = rdq_pkg::COUNT_BITS'(count);
    result.status = status;
  end

endmodule

@@ design/rdq_cell.sv @@
// One storage cell of a deque chain: holds, shifts in a neighbor's word, or loads.
module rdq_cell #(
  parameter int WORD_BITS = rdq_pkg::WORD_BITS_DEF,
  parameter int CW        = 5,
  parameter int IDX       = 0
) (
  input  logic                        clk,
  input  rdq_pkg::mode_t              mode,
  input  logic [CW-1:0]               count,
  input  logic signed [WORD_BITS-1:0] value,
  input  logic signed [WORD_BITS-1:0] lower,
  input  logic signed [WORD_BITS-1:0] upper,
  output logic signed [WORD_BITS-1:0] word
);

  always_ff @(posedge clk) begin
    case (mode)
      rdq_pkg::MODE_SHIFT_UP:   word <= lower;
      rdq_pkg::MODE_SHIFT_DOWN: word <= upper;
      rdq_pkg::MODE_LOAD: begin
        // a push at the chain's far end lands in the first free cell
        if (count == CW'(IDX)) word <= value;
      end
      default: word <= word;
    endcase
  end

endmodule

@@ design/rdq_chain.sv @@
// Row of deque cells with one end fixed at cell 0.
module rdq_chain #(
  parameter int DEPTH     = rdq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = rdq_pkg::WORD_BITS_DEF,
  parameter int CW        = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  rdq_pkg::mode_t              mode,
  input  logic [CW-1:0]               count,
  input  logic signed [WORD_BITS-1:0] value,
  output logic signed [WORD_BITS-1:0] end_word
);

  logic signed [WORD_BITS-1:0] words [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_BITS-1:0] lower;
    logic signed [WORD_BITS-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = value;
    end else begin : g_mid_lo
      assign lower = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = words[i];
    end else begin : g_mid_hi
      assign upper = words[i+1];
    end

    rdq_cell #(
      .WORD_BITS(WORD_BITS),
      .CW       (CW),
      .IDX      (i)
    ) u_cell (
      .clk  (clk),
      .mode (mode),
      .count(count),
      .value(value),
      .lower(lower),
      .upper(upper),
      .word (words[i])
    );
  end

  assign end_word = words[0];

endmodule

@@ design/rdq_check.sv @@
// Port-level checks for the reversible deque, bound to the top level.
module rdq_check #(
  parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_stall,
  input rdq_pkg::result_t result
);

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_empty_marks: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.count == '0 |->
      result.front_value == -32'sd1 && result.back_value == -32'sd1)
    else $error("empty deque must report -1 at both ends");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == rdq_pkg::ST_POP_EMPTY |-> result.count == '0)
    else $error("pop-on-empty flagged with words stored");

  a_push_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == rdq_pkg::ST_PUSH_FULL |->
      result.count == rdq_pkg::COUNT_BITS'(DEPTH))
    else $error("push-on-full flagged below capacity");

  a_single_word: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.count == 5'd1 && DEPTH < 32 |->
      result.front_value == result.back_value)
    else $error("one stored word must be both front and back");

endmodule

bind reversible_deque rdq_check #(.DEPTH(DEPTH)) u_rdq_check (
  .clk         (clk),
  .rst         (rst),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);

@@ tb/sv/tb_reversible_deque.sv @@
// Self-checking testbench for the reversible deque: random and directed items with checked results.
module tb_reversible_deque;

  localparam int SLOT_BITS = $clog2(rdq_pkg::DEPTH_DEF);
  // action codes outside the defined set; the block must treat them as no-ops
  localparam logic [rdq_pkg::ACTION_BITS-1:0] ACT_SPARE_A = 3'd5;
  localparam logic [rdq_pkg::ACTION_BITS-1:0] ACT_SPARE_B = 3'd6;
  localparam logic [rdq_pkg::ACTION_BITS-1:0] ACT_SPARE_C = 3'd7;
  localparam int RANDOM_ITEMS = 1450;
  localparam int CALM_ITEMS   = 200;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 80;

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  rdq_pkg::item_t   item;
  logic             result_valid;
  logic             result_stall;
  rdq_pkg::result_t result;

  bit hold_req = 0;
  bit calm     = 0;

  reversible_deque u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  class deque_scoreboard;
    logic [rdq_pkg::VALUE_BITS-1:0] words [rdq_pkg::DEPTH_DEF];
    logic [SLOT_BITS-1:0]           head = '0;
    logic [rdq_pkg::COUNT_BITS-1:0] fill = '0;
    bit                             flipped = 0;
    rdq_pkg::result_t               expected_results [$];
    int unsigned                    mismatches = 0;

    // advance the deque model by one item and return what the block should report
    function rdq_pkg::result_t step_deque(rdq_pkg::item_t it);
      rdq_pkg::result_t     r;
      logic                 at_head;
      logic [SLOT_BITS-1:0] slot;
      r.status = rdq_pkg::ST_OK;
      case (it.action)
        rdq_pkg::ACT_PUSH_BACK, rdq_pkg::ACT_PUSH_FRONT: begin
          if (fill == rdq_pkg::DEPTH_DEF) begin
            r.status = rdq_pkg::ST_PUSH_FULL;
          end else begin
            at_head = (it.action == rdq_pkg::ACT_PUSH_FRONT) ^ flipped;
            if (at_head) begin
              head = head - 1'b1;
              words[head] = it.value;
            end else begin
              slot = head + fill[SLOT_BITS-1:0];
              words[slot] = it.value;
            end
            fill = fill + 1'b1;
          end
        end
        rdq_pkg::ACT_POP_BACK, rdq_pkg::ACT_POP_FRONT: begin
          if (fill == 0) begin
            r.status = rdq_pkg::ST_POP_EMPTY;
          end else begin
            at_head = (it.action == rdq_pkg::ACT_POP_FRONT) ^ flipped;
            if (at_head) head = head + 1'b1;
            fill = fill - 1'b1;
          end
        end
        rdq_pkg::ACT_REVERSE: flipped = !flipped;
        default: ;
      endcase
      if (fill == 0) begin
        r.front_value = '1;
        r.back_value  = '1;
      end else begin
        // a full ring wraps: fill[3:0] is 0 and head-1 is the last slot
        slot = head + fill[SLOT_BITS-1:0] - 1'b1;
        r.front_value = flipped ? words[slot] : words[head];
        r.back_value  = flipped ? words[head] : words[slot];
      end
      r.count = fill;
      return r;
    endfunction

    function void note_item(rdq_pkg::item_t it);
      expected_results.insert(expected_results.size(), step_deque(it));
    endfunction

    function void report_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(rdq_pkg::result_t got);
      rdq_pkg::result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        return;
      end
      want = expected_results[0];
      expected_results.delete(0);
      report_field("front_value", want.front_value, got.front_value);
      report_field("back_value", want.back_value, got.back_value);
      report_field("count", 32'(want.count), 32'(got.count));
      report_field("status", 32'(want.status), 32'(got.status));
    endfunction
  endclass

  deque_scoreboard sb = new;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("FAILURE");
    $finish;
  end

  function automatic rdq_pkg::item_t make_item(logic [rdq_pkg::ACTION_BITS-1:0] act,
                                               logic [rdq_pkg::VALUE_BITS-1:0] val);
    rdq_pkg::item_t it;
    it.action = act;
    it.value  = val;
    return it;
  endfunction

  function automatic logic [rdq_pkg::ACTION_BITS-1:0] pick_action(int push_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return ACT_SPARE_A + 3'($urandom_range(0, 2));
    if (r < 11) return rdq_pkg::ACT_REVERSE;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? rdq_pkg::ACT_PUSH_FRONT : rdq_pkg::ACT_PUSH_BACK;
    return $urandom_range(0, 1) ? rdq_pkg::ACT_POP_FRONT : rdq_pkg::ACT_POP_BACK;
  endfunction

  function automatic logic [rdq_pkg::VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '1;
      3: return '0;
      4: return 32'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  function automatic int gap_len(int pct);
    return ($urandom_range(0, 99) < pct) ? int'($urandom_range(1, 19)) : 0;
  endfunction

  // offer one transaction, optionally after an idle gap, and hold it until accepted
  task automatic send_item(rdq_pkg::item_t it, int gap);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
  endtask

  // result side: check accepted transactions, drive stall bursts and the long hold-off
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) sb.check_result(result);
      if (hold_req) begin
        hold_req  = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 18);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    int push_pct;
    int gap_pct;
    int seg_left;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty queue: pops are rejected, reverse still toggles; then pushes at both ends, spare codes and pops
    send_item(make_item(rdq_pkg::ACT_POP_BACK, '0), 0);
    send_item(make_item(rdq_pkg::ACT_POP_FRONT, '1), 0);
    send_item(make_item(rdq_pkg::ACT_REVERSE, '0), 0);
    send_item(make_item(rdq_pkg::ACT_PUSH_BACK, 32'h7FFF_FFFF), 0);
    send_item(make_item(rdq_pkg::ACT_PUSH_FRONT, 32'h8000_0000), 0);
    send_item(make_item(rdq_pkg::ACT_REVERSE, '0), 0);
    send_item(make_item(rdq_pkg::ACT_PUSH_BACK, '1), 0);
    send_item(make_item(rdq_pkg::ACT_PUSH_FRONT, '0), 0);
    send_item(make_item(ACT_SPARE_A, 32'h1234_5678), 0);
    send_item(make_item(ACT_SPARE_B, '1), 0);
    send_item(make_item(ACT_SPARE_C, '0), 0);
    send_item(make_item(rdq_pkg::ACT_POP_FRONT, '0), 0);
    send_item(make_item(rdq_pkg::ACT_POP_BACK, '0), 0);
    // fill to capacity, then push on full at both ends
    repeat (rdq_pkg::DEPTH_DEF - 2)
      send_item(make_item($urandom_range(0, 1) ? rdq_pkg::ACT_PUSH_FRONT
                                               : rdq_pkg::ACT_PUSH_BACK, $urandom), 0);
    send_item(make_item(rdq_pkg::ACT_PUSH_BACK, 32'h5555_5555), 0);
    send_item(make_item(rdq_pkg::ACT_PUSH_FRONT, 32'hAAAA_AAAA), 0);

    // random segments, each with its own push bias so the queue swings full and empty
    seg_left = 0;
    push_pct = 50;
    gap_pct  = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 120);
        push_pct = $urandom_range(10, 90);
        gap_pct  = $urandom_range(0, 1) ? 15 : 0;
      end
      seg_left--;
      if (n == HOLD_AT) hold_req = 1;
      if (n >= RANDOM_ITEMS - CALM_ITEMS) begin
        calm    = 1;
        gap_pct = 0;
      end
      send_item(make_item(pick_action(push_pct), pick_value()), gap_len(gap_pct));
    end
    item_valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ reversible_deque.f @@
design/rdq_pkg.sv
design/rdq_cell.sv
design/rdq_chain.sv
design/reversible_deque.sv
design/rdq_check.sv
tb/sv/tb_reversible_deque.sv
